/* rtl/core/dlp_pkg.sv */
// Package for the decimal list parser: widths, character codes, status codes,
// parser and sequencer state encodings, and the power-of-ten divisor table.
// Standalone; used by decimal_list_parser_core.
package dlp_pkg;

  localparam int unsigned MaxValues     = 8;
  localparam int unsigned MaxFracDigits = 8;
  localparam int unsigned FracBits      = 16;

  localparam int unsigned ValueW   = 40;
  localparam int unsigned IntW     = ValueW - 1 - FracBits;
  localparam int unsigned IntExtW  = IntW + 4;
  localparam int unsigned FracAccW = 30;
  localparam int unsigned RemW     = FracAccW + 1;
  localparam int unsigned FdW      = $clog2(MaxFracDigits + 1);
  localparam int unsigned CntW     = $clog2(MaxValues + 1);
  localparam int unsigned DivCntW  = $clog2(FracBits + 1);
  localparam int unsigned CfgW     = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned StatusW  = 2;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [CfgW-1:0] CountReset = CfgW'(3);

  typedef enum logic [StatusW-1:0] {
    StatusOk     = 2'd0,
    StatusTooFew = 2'd1,
    StatusExtra  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhInt  = 3'b010,
    PhFrac = 3'b100
  } phase_e;

  typedef enum logic [3:0] {
    SeqIdle = 4'b0001,
    SeqDiv  = 4'b0010,
    SeqVal  = 4'b0100,
    SeqStat = 4'b1000
  } seq_e;

  function automatic logic [FracAccW-1:0] pow_ten(input logic [FdW-1:0] d);
    logic [FracAccW-1:0] r;
    case (d)
      4'd0:    r = FracAccW'(1);
      4'd1:    r = FracAccW'(10);
      4'd2:    r = FracAccW'(100);
      4'd3:    r = FracAccW'(1000);
      4'd4:    r = FracAccW'(10000);
      4'd5:    r = FracAccW'(100000);
      4'd6:    r = FracAccW'(1000000);
      4'd7:    r = FracAccW'(10000000);
      4'd8:    r = FracAccW'(100000000);
      default: r = FracAccW'(1000000000);
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/decimal_list_parser_core.sv */
// Decimal list parser core: character-serial parser with a bit-serial
// fraction divider and a registered result stage. Depends on dlp_pkg.
//
// Takes one ASCII character per item and yields each signed decimal value as
// Q23.16 when its terminator (space, comma or end of line) arrives, then one
// status result at the end of the line. A character that ends a value starts
// the restoring divider that turns the decimal fraction into 16 binary
// fraction bits, one quotient bit per cycle, and then forms the signed
// result. The end-of-line status follows as a further result. The input is
// not ready while a value is being converted or a result waits to be taken.
module decimal_list_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dlp_pkg::CfgW-1:0]          cfg_expected_count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        text_char_i,
  input  logic                              line_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              kind_o,
  output logic signed [dlp_pkg::ValueW-1:0] value_o,
  output logic [dlp_pkg::IdxW-1:0]          value_index_o,
  output logic [dlp_pkg::StatusW-1:0]       status_o,
  output logic                              saturated_o,
  output logic                              last_o
);

  localparam int unsigned IntW     = dlp_pkg::IntW;
  localparam int unsigned IntExtW  = dlp_pkg::IntExtW;
  localparam int unsigned FracAccW = dlp_pkg::FracAccW;
  localparam int unsigned RemW     = dlp_pkg::RemW;
  localparam int unsigned FdW      = dlp_pkg::FdW;
  localparam int unsigned CntW     = dlp_pkg::CntW;
  localparam int unsigned DivCntW  = dlp_pkg::DivCntW;
  localparam int unsigned FracBits = dlp_pkg::FracBits;
  localparam int unsigned ValueW   = dlp_pkg::ValueW;
  localparam int unsigned CfgW     = dlp_pkg::CfgW;
  localparam int unsigned IdxW     = dlp_pkg::IdxW;

  // configuration
  logic [CfgW-1:0] count_q;
  logic [CntW-1:0] eff_count;

  // parser state
  dlp_pkg::phase_e     phase_q, phase_d;
  logic [IntW-1:0]     int_q, int_d;
  logic [FracAccW-1:0] frac_q, frac_d;
  logic [FdW-1:0]      fd_q, fd_d;
  logic                neg_q, neg_d;
  logic                sat_q, sat_d;
  logic [CntW-1:0]     vs_q, vs_d;
  logic                trail_q, trail_d;

  // sequencer and divider
  dlp_pkg::seq_e       seq_q;
  logic [RemW-1:0]     rem_q;
  logic [FracAccW-1:0] den_q;
  logic [FracBits-1:0] quo_q;
  logic [DivCntW-1:0]  dcnt_q;
  logic [IntW-1:0]     res_int_q;
  logic                res_neg_q;
  logic                res_sat_q;
  logic [IdxW-1:0]     res_idx_q;
  logic                stat_pend_q;
  dlp_pkg::status_e    stat_code_q;

  // result register
  logic                  o_kind_q;
  logic [ValueW-1:0]     o_value_q;
  logic [IdxW-1:0]       o_idx_q;
  dlp_pkg::status_e      o_status_q;
  logic                  o_sat_q;
  logic                  o_last_q;

  logic                  accept;
  logic                  is_digit, is_term;
  logic [3:0]            digit;
  logic [IntExtW-1:0]    int_x10;
  logic                  emit;
  logic [CntW-1:0]       vs_emit;
  dlp_pkg::status_e      status_new;
  logic [RemW-1:0]       rem_sh;
  logic [ValueW-1:0]     mag;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (seq_q == dlp_pkg::SeqIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (seq_q == dlp_pkg::SeqVal) || (seq_q == dlp_pkg::SeqStat);

  assign kind_o        = o_kind_q;
  assign value_o       = o_value_q;
  assign value_index_o = o_idx_q;
  assign status_o      = o_status_q;
  assign saturated_o   = o_sat_q;
  assign last_o        = o_last_q;

  always_comb begin
    if (count_q == '0) begin
      eff_count = CntW'(1);
    end else if (CntW'(count_q) > CntW'(dlp_pkg::MaxValues)) begin
      eff_count = CntW'(dlp_pkg::MaxValues);
    end else begin
      eff_count = CntW'(count_q);
    end
  end

  assign is_digit = (text_char_i >= dlp_pkg::CharZero) && (text_char_i <= dlp_pkg::CharNine);
  assign is_term  = (text_char_i == dlp_pkg::CharSpace) || (text_char_i == dlp_pkg::CharComma);
  assign digit    = text_char_i[3:0];
  assign int_x10  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + IntExtW'(digit);

  // next parser state for the current character
  always_comb begin
    phase_d = phase_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fd_d    = fd_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    trail_d = trail_q;
    emit    = 1'b0;
    if (phase_q == dlp_pkg::PhIdle) begin
      if (vs_q >= eff_count) begin
        if (text_char_i != dlp_pkg::CharSpace) begin
          trail_d = 1'b1;
        end
      end else if (is_digit) begin
        phase_d = dlp_pkg::PhInt;
        int_d   = IntW'(digit);
      end else if (text_char_i == dlp_pkg::CharMinus) begin
        phase_d = dlp_pkg::PhInt;
        neg_d   = 1'b1;
      end
    end else if (is_term) begin
      emit = 1'b1;
      if (text_char_i == dlp_pkg::CharComma && (vs_q + CntW'(1)) >= eff_count) begin
        trail_d = 1'b1;
      end
    end else if (is_digit) begin
      if (phase_q == dlp_pkg::PhInt) begin
        if (int_x10[IntExtW-1:IntW] != '0) begin
          int_d = '1;
          sat_d = 1'b1;
        end else begin
          int_d = int_x10[IntW-1:0];
        end
      end else if (fd_q < FdW'(dlp_pkg::MaxFracDigits)) begin
        frac_d = (frac_q << 3) + (frac_q << 1) + FracAccW'(digit);
        fd_d   = fd_q + FdW'(1);
      end
    end else if (text_char_i == dlp_pkg::CharDot && phase_q == dlp_pkg::PhInt) begin
      phase_d = dlp_pkg::PhFrac;
    end
    if (line_end_i && phase_d != dlp_pkg::PhIdle) begin
      emit = 1'b1;
    end
  end

  assign vs_emit = vs_q + CntW'(emit);

  always_comb begin
    if (vs_emit < eff_count) begin
      status_new = dlp_pkg::StatusTooFew;
    end else if (trail_d) begin
      status_new = dlp_pkg::StatusExtra;
    end else begin
      status_new = dlp_pkg::StatusOk;
    end
  end

  assign rem_sh = {rem_q[RemW-2:0], 1'b0};
  assign mag    = {1'b0, res_int_q, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= dlp_pkg::CountReset;
      phase_q <= dlp_pkg::PhIdle;
      int_q   <= '0;
      frac_q  <= '0;
      fd_q    <= '0;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      vs_q    <= '0;
      trail_q <= 1'b0;
      seq_q   <= dlp_pkg::SeqIdle;
      dcnt_q  <= '0;
      stat_pend_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_expected_count_i;
      end
      case (seq_q)
        dlp_pkg::SeqIdle: begin
          if (accept) begin
            if (emit || line_end_i) begin
              phase_q <= dlp_pkg::PhIdle;
              int_q   <= '0;
              frac_q  <= '0;
              fd_q    <= '0;
              neg_q   <= 1'b0;
              sat_q   <= 1'b0;
            end else begin
              phase_q <= phase_d;
              int_q   <= int_d;
              frac_q  <= frac_d;
              fd_q    <= fd_d;
              neg_q   <= neg_d;
              sat_q   <= sat_d;
            end
            if (line_end_i) begin
              vs_q    <= '0;
              trail_q <= 1'b0;
            end else begin
              vs_q    <= vs_emit;
              trail_q <= trail_d;
            end
            stat_pend_q <= line_end_i;
            if (emit) begin
              dcnt_q <= '0;
              seq_q  <= dlp_pkg::SeqDiv;
            end else if (line_end_i) begin
              seq_q  <= dlp_pkg::SeqStat;
            end
          end
        end
        dlp_pkg::SeqDiv: begin
          dcnt_q <= dcnt_q + DivCntW'(1);
          if (dcnt_q == DivCntW'(FracBits)) begin
            seq_q <= dlp_pkg::SeqVal;
          end
        end
        dlp_pkg::SeqVal: begin
          if (out_ready_i) begin
            if (stat_pend_q) begin
              seq_q <= dlp_pkg::SeqStat;
            end else begin
              seq_q <= dlp_pkg::SeqIdle;
            end
          end
        end
        dlp_pkg::SeqStat: begin
          if (out_ready_i) begin
            stat_pend_q <= 1'b0;
            seq_q       <= dlp_pkg::SeqIdle;
          end
        end
        default: begin
          seq_q <= dlp_pkg::SeqIdle;
        end
      endcase
    end
  end

  // divider, token snapshot and result payload
  always_ff @(posedge clk_i) begin
    case (seq_q)
      dlp_pkg::SeqIdle: begin
        if (accept && emit) begin
          rem_q       <= RemW'(frac_d);
          den_q       <= dlp_pkg::pow_ten(fd_d);
          quo_q       <= '0;
          res_int_q   <= int_d;
          res_neg_q   <= neg_d;
          res_sat_q   <= sat_d;
          res_idx_q   <= vs_q[IdxW-1:0];
          stat_code_q <= status_new;
        end else if (accept && line_end_i) begin
          o_kind_q   <= 1'b1;
          o_value_q  <= '0;
          o_idx_q    <= '0;
          o_status_q <= status_new;
          o_sat_q    <= 1'b0;
          o_last_q   <= 1'b1;
        end
      end
      dlp_pkg::SeqDiv: begin
        if (dcnt_q == DivCntW'(FracBits)) begin
          o_kind_q   <= 1'b0;
          o_value_q  <= res_neg_q ? (ValueW'(0) - mag) : mag;
          o_idx_q    <= res_idx_q;
          o_status_q <= dlp_pkg::StatusOk;
          o_sat_q    <= res_sat_q;
          o_last_q   <= 1'b0;
        end else if (rem_sh >= RemW'(den_q)) begin
          rem_q <= rem_sh - RemW'(den_q);
          quo_q <= {quo_q[FracBits-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[FracBits-2:0], 1'b0};
        end
      end
      dlp_pkg::SeqVal: begin
        if (out_ready_i && stat_pend_q) begin
          o_kind_q   <= 1'b1;
          o_value_q  <= '0;
          o_idx_q    <= '0;
          o_status_q <= stat_code_q;
          o_sat_q    <= 1'b0;
          o_last_q   <= 1'b1;
        end
      end
      default: begin
        o_kind_q <= o_kind_q;
      end
    endcase
  end

endmodule
